FILE: sv/ppr_pkg.sv
// shared types and constants for the page replacement block
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

    localparam int DEF_FRAMES     = 8;
    localparam int DEF_PAGES      = 32;
    localparam int DEF_COUNT_BITS = 16;

    // policy register codes
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_LRU  = 2'd1;
    localparam logic [1:0] POL_LFU  = 2'd2;

    // register index decoded from paddr[2]
    localparam logic REG_IDX_POLICY = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PASS,
        ST_HITUSE,
        ST_LOAD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic eq;
        logic lt;
        logic gt;
    } t_cmp_res;

endpackage

`default_nettype wire

FILE: sv/ppr_cmp_unit.sv
// shared magnitude and equality comparator
`timescale 1ns / 1ps
`default_nettype none

module ppr_cmp_unit
    import ppr_pkg::*;
#(
    parameter int W = DEF_COUNT_BITS
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output t_cmp_res          o_res
);

    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.lt = (i_a < i_b);
        o_res.gt = (i_a > i_b);
    end

endmodule

`default_nettype wire

FILE: sv/ppr_frame_mem.sv
// frame store: page, age and use count per frame, with valid bits for reset values
`timescale 1ns / 1ps
`default_nettype none

module ppr_frame_mem
    import ppr_pkg::*;
#(
    parameter int FRAMES     = DEF_FRAMES,
    parameter int PAGES      = DEF_PAGES,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    localparam int FIDX_W    = $clog2(FRAMES),
    localparam int PAGE_W    = $clog2(PAGES)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [FIDX_W-1:0]     i_rd_addr,
    input  wire logic                  i_wr_en,
    input  wire logic [FIDX_W-1:0]     i_wr_addr,
    input  wire logic [PAGE_W-1:0]     i_wr_page,
    input  wire logic [COUNT_BITS-1:0] i_wr_age,
    input  wire logic [COUNT_BITS-1:0] i_wr_uses,
    output logic      [PAGE_W-1:0]     o_rd_page,
    output logic      [COUNT_BITS-1:0] o_rd_age,
    output logic      [COUNT_BITS-1:0] o_rd_uses
);

    logic [PAGE_W-1:0]     r_mem_page [FRAMES];
    logic [COUNT_BITS-1:0] r_mem_age  [FRAMES];
    logic [COUNT_BITS-1:0] r_mem_uses [FRAMES];
    logic [FRAMES-1:0]     r_valid;

    logic [PAGE_W-1:0]     r_rd_page;
    logic [COUNT_BITS-1:0] r_rd_age;
    logic [COUNT_BITS-1:0] r_rd_uses;
    logic                  r_rd_valid;
    logic [FIDX_W-1:0]     r_rd_idx;

    logic [PAGE_W-1:0]     w_rst_page [FRAMES];

    // page held by each frame after reset
    for (genvar g = 0; g < FRAMES; g++) begin : g_rst_page
        assign w_rst_page[g] = PAGE_W'(g % PAGES);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_page[i_wr_addr] <= i_wr_page;
            r_mem_age[i_wr_addr]  <= i_wr_age;
            r_mem_uses[i_wr_addr] <= i_wr_uses;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_page  <= r_mem_page[i_rd_addr];
        r_rd_age   <= r_mem_age[i_rd_addr];
        r_rd_uses  <= r_mem_uses[i_rd_addr];
        r_rd_valid <= r_valid[i_rd_addr];
        r_rd_idx   <= i_rd_addr;
    end

    always_comb begin
        o_rd_page = r_rd_valid ? r_rd_page : w_rst_page[r_rd_idx];
        o_rd_age  = r_rd_valid ? r_rd_age  : '0;
        o_rd_uses = r_rd_valid ? r_rd_uses : '0;
    end

endmodule

`default_nettype wire

FILE: sv/page_replacement_policy.sv
// page replacement block top level: sequencer, tallies, config register and result stage
// A reference is taken in the idle state. A pass over the frame store then finds the
// page, one frame per cycle through the registered read port. A second pass picks the
// victim and, under FIFO and LRU, ages the frames. The load state then writes the frame
// and the done state hands the result to the output register. A FIFO or LRU hit skips
// the load; it still ages the frames in the second pass but picks no victim. An LFU
// hit skips the second pass and counts the use in its own state. The frame store has
// one read and one write port, and one shared comparator serves both passes.
// A new reference is taken only once the previous one has reached the output register.
// The result waits there until taken, and a stalled output holds back the next reference.
`timescale 1ns / 1ps
`default_nettype none

module page_replacement_policy
    import ppr_pkg::*;
#(
    parameter int FRAMES     = DEF_FRAMES,
    parameter int PAGES      = DEF_PAGES,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    localparam int FIDX_W    = $clog2(FRAMES),
    localparam int PAGE_W    = $clog2(PAGES)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [PAGE_W-1:0]     i_page_number,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_hit,
    output logic      [FIDX_W-1:0]     o_frame,
    output logic      [PAGE_W-1:0]     o_evicted_page,
    output logic      [COUNT_BITS-1:0] o_hits_total,
    output logic      [COUNT_BITS-1:0] o_misses_total
);

    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W = (PAGE_W > COUNT_BITS) ? PAGE_W : COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    t_state                r_state, n_state;
    logic [1:0]            r_policy;
    logic [PAGE_W-1:0]     r_page_in, n_page_in;
    logic [CNT_W-1:0]      r_iss, n_iss;
    logic                  r_rd_vld, n_rd_vld;
    logic [FIDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic                  r_found, n_found;
    logic [FIDX_W-1:0]     r_where, n_where;
    logic [COUNT_BITS-1:0] r_best, n_best;
    logic [PAGE_W-1:0]     r_evict, n_evict;
    logic [COUNT_BITS-1:0] r_hit_age, n_hit_age;
    logic [COUNT_BITS-1:0] r_hit_uses, n_hit_uses;
    logic [COUNT_BITS-1:0] r_hit_tally, n_hit_tally;
    logic [COUNT_BITS-1:0] r_miss_tally, n_miss_tally;
    logic                  r_o_valid, n_o_valid;
    logic                  r_o_hit, n_o_hit;
    logic [FIDX_W-1:0]     r_o_frame, n_o_frame;
    logic [PAGE_W-1:0]     r_o_evicted, n_o_evicted;
    logic [COUNT_BITS-1:0] r_o_hits, n_o_hits;
    logic [COUNT_BITS-1:0] r_o_misses, n_o_misses;

    logic [FIDX_W-1:0]     w_rd_addr;
    logic                  w_wr_en;
    logic [FIDX_W-1:0]     w_wr_addr;
    logic [PAGE_W-1:0]     w_wr_page;
    logic [COUNT_BITS-1:0] w_wr_age;
    logic [COUNT_BITS-1:0] w_wr_uses;
    logic [PAGE_W-1:0]     w_rd_page;
    logic [COUNT_BITS-1:0] w_rd_age;
    logic [COUNT_BITS-1:0] w_rd_uses;
    logic [CMP_W-1:0]      w_cmp_a;
    logic [CMP_W-1:0]      w_cmp_b;
    t_cmp_res              w_cmp;
    logic                  w_lfu;
    logic                  w_lru;
    logic                  w_last;
    logic                  w_out_free;
    logic                  w_cfg_wr;
    logic [COUNT_BITS-1:0] w_age_base;
    logic [COUNT_BITS-1:0] w_age_new;

    function automatic logic [COUNT_BITS-1:0] f_sat_inc(input logic [COUNT_BITS-1:0] v);
        f_sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    ppr_frame_mem #(
        .FRAMES     (FRAMES),
        .PAGES      (PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_page (w_wr_page),
        .i_wr_age  (w_wr_age),
        .i_wr_uses (w_wr_uses),
        .o_rd_page (w_rd_page),
        .o_rd_age  (w_rd_age),
        .o_rd_uses (w_rd_uses)
    );

    ppr_cmp_unit #(
        .W (CMP_W)
    ) u_cmp (
        .i_a   (w_cmp_a),
        .i_b   (w_cmp_b),
        .o_res (w_cmp)
    );

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_IDX_POLICY) ? 32'(r_policy) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIFO;
        end else if (w_cfg_wr && (paddr[2] == REG_IDX_POLICY)) begin
            r_policy <= pwdata[1:0];
        end
    end

    assign w_lfu      = r_policy[1];
    assign w_lru      = (r_policy == POL_LRU);
    assign w_last     = r_rd_vld && (r_rd_idx == FIDX_W'(FRAMES - 1));
    assign w_out_free = !r_o_valid || i_out_ready;

    assign w_age_base = (w_lru && r_found && (r_rd_idx == r_where)) ? '0 : w_rd_age;
    assign w_age_new  = f_sat_inc(w_age_base);

    // shared comparator operands
    always_comb begin
        if (r_state == ST_SEARCH) begin
            w_cmp_a = CMP_W'(r_page_in);
            w_cmp_b = CMP_W'(w_rd_page);
        end else if (w_lfu) begin
            w_cmp_a = CMP_W'(w_rd_uses);
            w_cmp_b = CMP_W'(r_best);
        end else begin
            w_cmp_a = CMP_W'(w_age_new);
            w_cmp_b = CMP_W'(r_best);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (w_last) begin
                    n_state = (w_lfu && n_found) ? ST_HITUSE : ST_PASS;
                end
            end
            ST_PASS: begin
                if (w_last) begin
                    n_state = r_found ? ST_DONE : ST_LOAD;
                end
            end
            ST_HITUSE: begin
                n_state = ST_DONE;
            end
            ST_LOAD: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and frame store control
    always_comb begin
        n_page_in    = r_page_in;
        n_iss        = r_iss;
        n_rd_vld     = r_rd_vld;
        n_rd_idx     = r_rd_idx;
        n_found      = r_found;
        n_where      = r_where;
        n_best       = r_best;
        n_evict      = r_evict;
        n_hit_age    = r_hit_age;
        n_hit_uses   = r_hit_uses;
        n_hit_tally  = r_hit_tally;
        n_miss_tally = r_miss_tally;
        n_o_valid    = r_o_valid && !i_out_ready;
        n_o_hit      = r_o_hit;
        n_o_frame    = r_o_frame;
        n_o_evicted  = r_o_evicted;
        n_o_hits     = r_o_hits;
        n_o_misses   = r_o_misses;
        o_in_ready   = 1'b0;
        w_rd_addr    = r_iss[FIDX_W-1:0];
        w_wr_en      = 1'b0;
        w_wr_addr    = r_rd_idx;
        w_wr_page    = w_rd_page;
        w_wr_age     = w_age_new;
        w_wr_uses    = w_rd_uses;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_page_in = i_page_number;
                    n_found   = 1'b0;
                    n_iss     = '0;
                    n_rd_vld  = 1'b0;
                end
            end
            ST_SEARCH, ST_PASS: begin
                if (r_iss < CNT_W'(FRAMES)) begin
                    n_iss    = r_iss + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_iss[FIDX_W-1:0];
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_state == ST_SEARCH) begin
                    if (r_rd_vld && w_cmp.eq && !r_found) begin
                        n_found    = 1'b1;
                        n_where    = r_rd_idx;
                        n_hit_age  = w_rd_age;
                        n_hit_uses = w_rd_uses;
                    end
                    if (w_last) begin
                        n_iss    = '0;
                        n_rd_vld = 1'b0;
                        n_best   = w_lfu ? CNT_MAX : '0;
                    end
                end else if (r_rd_vld) begin
                    if (w_lfu) begin
                        // least used, highest index on ties
                        if (!w_cmp.gt) begin
                            n_best  = w_rd_uses;
                            n_where = r_rd_idx;
                            n_evict = w_rd_page;
                        end
                    end else begin
                        w_wr_en = 1'b1;
                        // oldest, highest index on ties
                        if (!r_found && !w_cmp.lt) begin
                            n_best  = w_age_new;
                            n_where = r_rd_idx;
                            n_evict = w_rd_page;
                        end
                    end
                end
            end
            ST_HITUSE: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_where;
                w_wr_page = r_page_in;
                w_wr_age  = r_hit_age;
                w_wr_uses = f_sat_inc(r_hit_uses);
            end
            ST_LOAD: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_where;
                w_wr_page = r_page_in;
                w_wr_age  = '0;
                w_wr_uses = '0;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    if (r_found) begin
                        n_hit_tally = f_sat_inc(r_hit_tally);
                    end else begin
                        n_miss_tally = f_sat_inc(r_miss_tally);
                    end
                    n_o_valid   = 1'b1;
                    n_o_hit     = r_found;
                    n_o_frame   = r_where;
                    n_o_evicted = r_found ? '0 : r_evict;
                    n_o_hits    = n_hit_tally;
                    n_o_misses  = n_miss_tally;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_iss        <= '0;
            r_rd_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_hit_tally  <= '0;
            r_miss_tally <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_iss        <= n_iss;
            r_rd_vld     <= n_rd_vld;
            r_found      <= n_found;
            r_hit_tally  <= n_hit_tally;
            r_miss_tally <= n_miss_tally;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page_in   <= n_page_in;
        r_rd_idx    <= n_rd_idx;
        r_where     <= n_where;
        r_best      <= n_best;
        r_evict     <= n_evict;
        r_hit_age   <= n_hit_age;
        r_hit_uses  <= n_hit_uses;
        r_o_hit     <= n_o_hit;
        r_o_frame   <= n_o_frame;
        r_o_evicted <= n_o_evicted;
        r_o_hits    <= n_o_hits;
        r_o_misses  <= n_o_misses;
    end

    assign o_out_valid    = r_o_valid;
    assign o_hit          = r_o_hit;
    assign o_frame        = r_o_frame;
    assign o_evicted_page = r_o_evicted;
    assign o_hits_total   = r_o_hits;
    assign o_misses_total = r_o_misses;

`ifndef SYNTHESIS
    a_lfu_hit_skips_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS) && w_lfu |-> !r_found)
        else $error("lfu hit entered the victim pass");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> (o_evicted_page == '0))
        else $error("hit reported an evicted page");

    a_accept_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> (r_state == ST_SEARCH) && (r_iss == '0))
        else $error("transfer did not start the search pass");

    a_write_only_when_updating: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == ST_PASS) || (r_state == ST_HITUSE) || (r_state == ST_LOAD))
        else $error("frame store written outside an update step");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
// testbench for the page replacement block: directed and random references checked against a predictor
`timescale 1ns / 1ps

module tb
    import ppr_pkg::*;
();

    localparam int NFRAMES = DEF_FRAMES;
    localparam logic [1:0] POL_LFU_ALIAS = POL_LFU | POL_LRU;
    localparam logic [2:0] ADDR_POLICY = {REG_IDX_POLICY, 2'b00};

    typedef struct packed {
        logic        hit;
        logic [2:0]  frame;
        logic [4:0]  evicted;
        logic [15:0] hits;
        logic [15:0] misses;
    } t_page_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [4:0]  i_page_number;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_hit;
    logic [2:0]  o_frame;
    logic [4:0]  o_evicted_page;
    logic [15:0] o_hits_total;
    logic [15:0] o_misses_total;

    // predictor state
    logic [4:0]  resident_page[NFRAMES];
    logic [15:0] frame_age[NFRAMES];
    logic [15:0] frame_uses[NFRAMES];
    logic [15:0] pred_hits;
    logic [15:0] pred_misses;
    logic [1:0]  cur_policy;

    t_page_result pending_results[$];
    int unsigned  error_count;
    bit           no_gaps;
    int unsigned  ready_run;

    page_replacement_policy dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_page_number  (i_page_number),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_frame        (o_frame),
        .o_evicted_page (o_evicted_page),
        .o_hits_total   (o_hits_total),
        .o_misses_total (o_misses_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    function automatic void reset_predictor();
        for (int i = 0; i < NFRAMES; i++) begin
            resident_page[i] = 5'(i);
            frame_age[i] = '0;
            frame_uses[i] = '0;
        end
        pred_hits = '0;
        pred_misses = '0;
        cur_policy = POL_FIFO;
    endfunction

    function automatic t_page_result reference_page(logic [4:0] pg);
        t_page_result r;
        logic         found;
        logic [2:0]   where;
        logic [15:0]  best;
        found = 1'b0;
        where = '0;
        for (int i = 0; i < NFRAMES; i++) begin
            if (!found && resident_page[i] == pg) begin
                found = 1'b1;
                where = 3'(i);
            end
        end
        if (cur_policy[1]) begin
            if (found) begin
                frame_uses[where] = sat_inc(frame_uses[where]);
            end else begin
                best = 16'hFFFF;
                for (int i = 0; i < NFRAMES; i++) begin
                    if (frame_uses[i] <= best) begin
                        best = frame_uses[i];
                        where = 3'(i);
                    end
                end
            end
        end else begin
            if (found && cur_policy == POL_LRU) frame_age[where] = '0;
            for (int i = 0; i < NFRAMES; i++) frame_age[i] = sat_inc(frame_age[i]);
            if (!found) begin
                best = '0;
                for (int i = 0; i < NFRAMES; i++) begin
                    if (frame_age[i] >= best) begin
                        best = frame_age[i];
                        where = 3'(i);
                    end
                end
            end
        end
        r.evicted = '0;
        if (found) begin
            pred_hits = sat_inc(pred_hits);
        end else begin
            r.evicted = resident_page[where];
            resident_page[where] = pg;
            frame_age[where] = '0;
            frame_uses[where] = '0;
            pred_misses = sat_inc(pred_misses);
        end
        r.hit = found;
        r.frame = where;
        r.hits = pred_hits;
        r.misses = pred_misses;
        return r;
    endfunction

    // result side: random stalls, checked transfer by transfer
    initial begin
        i_out_ready <= 1'b0;
        ready_run = 0;
        forever begin
            @(posedge i_clk);
            if (no_gaps) begin
                i_out_ready <= 1'b1;
                ready_run = 0;
            end else if (ready_run != 0) begin
                ready_run--;
            end else if (!i_out_ready) begin
                i_out_ready <= 1'b1;
                ready_run = $urandom_range(1, 8);
            end else begin
                i_out_ready <= 1'b0;
                ready_run = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        t_page_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    error_count++;
                end
                if (o_frame !== want.frame) begin
                    $error("frame: expected %0d, got %0d", want.frame, o_frame);
                    error_count++;
                end
                if (o_evicted_page !== want.evicted) begin
                    $error("evicted_page: expected %0d, got %0d", want.evicted, o_evicted_page);
                    error_count++;
                end
                if (o_hits_total !== want.hits) begin
                    $error("hits_total: expected %0d, got %0d", want.hits, o_hits_total);
                    error_count++;
                end
                if (o_misses_total !== want.misses) begin
                    $error("misses_total: expected %0d, got %0d", want.misses, o_misses_total);
                    error_count++;
                end
            end
        end
    end

    task automatic send_ref(input logic [4:0] pg);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_page_number <= pg;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(reference_page(pg));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_policy(input logic [1:0] value);
        drain_results();
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_POLICY;
        pwdata <= {30'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_policy = value;
    endtask

    function automatic logic [4:0] pick_page(logic [4:0] base);
        if ($urandom_range(0, 99) < 70) return base + 5'($urandom_range(0, 9));
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic run_random(input int unsigned count, input bit drain_each);
        logic [4:0] base;
        base = 5'($urandom_range(0, 31));
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 19) == 0) base = 5'($urandom_range(0, 31));
            if (drain_each) drain_results();
            send_ref(pick_page(base));
        end
        drain_results();
    endtask

    // reset contents, equal ages so the top frame is the victim, field extremes
    task automatic test_fifo_ties();
        send_ref(5'd0);
        send_ref(5'd31);
        send_ref(5'd7);
        send_ref(5'd16);
        send_ref(5'd31);
        send_ref(5'd1);
        send_ref(5'd21);
    endtask

    task automatic test_lru();
        write_policy(POL_LRU);
        send_ref(5'd2);
        send_ref(5'd3);
        send_ref(5'd24);
        send_ref(5'd2);
        send_ref(5'd10);
        send_ref(5'd11);
    endtask

    task automatic test_lfu();
        write_policy(POL_LFU);
        send_ref(5'd0);
        send_ref(5'd0);
        send_ref(5'd4);
        send_ref(5'd30);
        send_ref(5'd29);
        send_ref(5'd30);
    endtask

    task automatic test_policy_alias();
        write_policy(POL_LFU_ALIAS);
        send_ref(5'd12);
        send_ref(5'd12);
        send_ref(5'd13);
        send_ref(5'd31);
    endtask

    task automatic test_random_policies();
        write_policy(POL_FIFO);
        run_random(70, 1'b0);
        write_policy(POL_LRU);
        run_random(70, 1'b0);
        write_policy(POL_LFU);
        run_random(70, 1'b0);
        write_policy(POL_LFU_ALIAS);
        run_random(40, 1'b0);
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        write_policy(POL_LRU);
        run_random(60, 1'b0);
        write_policy(POL_FIFO);
        run_random(30, 1'b0);
        no_gaps = 1'b0;
    endtask

    task automatic test_drained_sender();
        write_policy(POL_LFU);
        run_random(40, 1'b1);
    endtask

    initial begin
        error_count = 0;
        no_gaps = 1'b0;
        reset_predictor();
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_in_valid <= 1'b0;
        i_page_number <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fifo_ties();
        test_lru();
        test_lfu();
        test_policy_alias();
        test_random_policies();
        test_back_to_back();
        test_drained_sender();

        drain_results();
        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: page_replacement_policy.f
sv/ppr_pkg.sv
sv/ppr_cmp_unit.sv
sv/ppr_frame_mem.sv
sv/page_replacement_policy.sv
sim/tb.sv
